// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock is clk, reset is rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond true at an edge -> prop true at the same edge
`define ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond true at an edge -> prop true at the next edge
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/cti_pkg.sv =====
package cti_pkg;

    // input transaction opcodes
    localparam logic [1:0] OP_WRITE_X  = 2'd0;
    localparam logic [1:0] OP_WRITE_Y  = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;   // accepted and dropped

    // configuration register indexes
    localparam logic [1:0] CFG_Y_MODE       = 2'd0;
    localparam logic [1:0] CFG_TABLE_LENGTH = 2'd1;
    localparam logic [1:0] CFG_Y_STRIDE     = 2'd2;

    localparam int OPCODE_W      = 2;
    localparam int ENTRY_INDEX_W = 6;
    localparam int CFG_INDEX_W   = 2;
    localparam int LENGTH_W      = 7;
    localparam int MIN_LENGTH    = 4;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 7'd40;

    // command to the shared arithmetic unit
    typedef struct packed {
        logic start;
        logic divide;   // 0: multiply a * b, 1: divide a / d
    } cti_cmd_t;

endpackage

// ===== src/cti_table_mem.sv =====
module cti_table_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 56
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/cti_arith_unit.sv =====
// Bit-serial shift-add multiplier and restoring divider on shared registers.
module cti_arith_unit #(
    parameter int AW = 230,
    parameter int BW = 62,
    parameter int DW = 168
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cti_pkg::cti_cmd_t cmd,
    input  logic [AW-1:0]     a_in,
    input  logic [BW-1:0]     b_in,
    input  logic [DW-1:0]     d_in,
    output logic              busy,
    output logic [AW-1:0]     result
);

    localparam int CW = $clog2(AW + 1);

    logic          busy_reg, busy_next;
    logic          div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0] mplr_reg, mplr_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    logic [DW:0]   rem_sh;
    logic [DW+1:0] rem_diff;

    always_comb
    begin
        busy_next  = busy_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        rem_sh     = {rem_reg, acc_reg[AW-1]};
        rem_diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.divide;
            if (cmd.divide)
            begin
                acc_next = a_in;
                rem_next = '0;
                dvs_next = d_in;
                cnt_next = CW'(AW);
            end
            else
            begin
                acc_next   = '0;
                mcand_next = a_in;
                mplr_next  = b_in;
            end
        end
        else if (busy_reg && !div_reg)
        begin
            // stop once the multiplier runs out of ones
            if (mplr_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (mplr_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[AW-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[BW-1:1]};
            end
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, shifted into the dividend register
            if (!rem_diff[DW+1])
            begin
                rem_next = rem_diff[DW-1:0];
                acc_next = {acc_reg[AW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                acc_next = {acc_reg[AW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

// ===== src/cubic_table_interpolator.sv =====
// Cubic table interpolator. Holds an x table and a y table of unsigned Q32.24
// points (TABLE_DEPTH entries each), loaded one entry per transaction with
// opcodes 0 and 1; a write returns nothing. A query (opcode 2) binary-searches
// the x table for the interval around the point, loads a four-entry window and
// evaluates the four-point Lagrange cubic exactly, each term truncated toward
// zero, the sum saturated to the output range; out_of_range flags points below
// the first or above the last x. Per term, a query runs four bit-serial
// multiplies, the y product (plus the stride product in stride mode) and one
// restoring division on a single shift-add/subtract unit, which sets the rate;
// the block takes no new transaction while a query is in flight, but it accepts
// the next one while a finished result still waits on the output register.
// A query equal to the last x returns the last y without interpolating. Table
// contents are undefined until written. The user must write configuration only
// while idle; the block itself does not enforce it. Configuration: y_mode
// (0 table, 1 y = y_stride * index), table_length (clamped to 4..TABLE_DEPTH)
// and y_stride.
`include "assert_macros.svh"

module cubic_table_interpolator #(
    parameter int TABLE_DEPTH   = 64,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cti_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [32+FRACTION_BITS-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cti_pkg::OPCODE_W-1:0]        opcode,
    input  logic [cti_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    input  logic [32+FRACTION_BITS-1:0]         data_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [32+FRACTION_BITS-1:0]         result_value,
    output logic                                out_of_range
);

    localparam int VB = 32 + FRACTION_BITS;     // value width
    localparam int IW = $clog2(TABLE_DEPTH);    // table index width
    localparam int YW = VB + IW;                // y in stride mode
    localparam int PW = 3 * VB;                 // product of three differences
    localparam int TW = YW + PW;                // y times numerator
    localparam int SW = TW + 3;                 // signed sum of four terms

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHKN, S_SRCH, S_SCMP, S_LDA, S_LDB,
        S_TERM, S_ISSUE, S_WAIT, S_FIN, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        STEP_N1, STEP_N2, STEP_D1, STEP_D2, STEP_Y, STEP_T, STEP_DIV, STEP_LAST
    } step_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic          y_mode_reg;
    logic [cti_pkg::LENGTH_W-1:0] table_length_reg;
    logic [VB-1:0] y_stride_reg;

    logic [1:0]    k_reg, k_next;
    logic [1:0]    ld_cnt_reg, ld_cnt_next;
    logic [IW-1:0] last_reg, last_next;
    logic [IW-1:0] lo_reg, lo_next;
    logic [IW-1:0] hi_reg, hi_next;
    logic [IW-1:0] base_reg, base_next;
    logic [IW-1:0] rd_addr_reg, rd_addr_next;
    logic          oor_reg, oor_next;
    logic          out_valid_reg;
    logic [VB-1:0] q_reg, q_next;
    logic [VB-1:0] hold_reg, hold_next;
    logic [VB-1:0] result_reg;
    logic          out_oor_reg;
    logic [VB-1:0] xw_reg [4];
    logic [VB-1:0] xw_next [4];
    logic [PW-1:0] num_reg, num_next;
    logic [PW-1:0] den_reg, den_next;
    logic [YW-1:0] yv_reg, yv_next;
    logic [SW-1:0] sum_reg, sum_next;

    logic [VB-1:0] x_rd, y_rd;
    logic          accept, out_free, out_load;
    logic          x_we, y_we, idx_ok;
    logic [IW-1:0] span;

    // differences against the window: q - x_i and x_k - x_i for i = 1..3
    logic [VB-1:0] dq [4];
    logic [VB-1:0] dk [4];
    logic [3:0]    lt_q, lt_k;
    logic          term_neg, term_done;
    logic [TW-1:0] term_mag;

    cti_pkg::cti_cmd_t cmd;
    logic [TW-1:0] unit_a;
    logic [YW-1:0] unit_b;
    logic          unit_busy;
    logic [TW-1:0] unit_res;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_DONE) && out_free;
    assign idx_ok   = int'(entry_index) < TABLE_DEPTH;
    assign x_we     = accept && (opcode == cti_pkg::OP_WRITE_X) && idx_ok;
    assign y_we     = accept && (opcode == cti_pkg::OP_WRITE_Y) && idx_ok;
    assign span     = hi_reg - lo_reg;

    cti_table_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(VB)) u_x_mem (
        .clk     (clk),
        .wr_en   (x_we),
        .wr_addr (IW'(entry_index)),
        .wr_data (data_value),
        .rd_addr (rd_addr_next),
        .rd_data (x_rd)
    );

    cti_table_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(VB)) u_y_mem (
        .clk     (clk),
        .wr_en   (y_we),
        .wr_addr (IW'(entry_index)),
        .wr_data (data_value),
        .rd_addr (rd_addr_next),
        .rd_data (y_rd)
    );

    cti_arith_unit #(.AW(TW), .BW(YW), .DW(PW)) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a_in   (unit_a),
        .b_in   (unit_b),
        .d_in   (den_reg),
        .busy   (unit_busy),
        .result (unit_res)
    );

    // window differences; xw_reg[0] is always the term's own x
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lt_q[i] = q_reg < xw_reg[i];
            lt_k[i] = xw_reg[0] < xw_reg[i];
            dq[i]   = lt_q[i] ? (xw_reg[i] - q_reg) : (q_reg - xw_reg[i]);
            dk[i]   = lt_k[i] ? (xw_reg[i] - xw_reg[0]) : (xw_reg[0] - xw_reg[i]);
        end
        term_neg = lt_q[1] ^ lt_q[2] ^ lt_q[3] ^ lt_k[1] ^ lt_k[2] ^ lt_k[3];
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        k_next       = k_reg;
        ld_cnt_next  = ld_cnt_reg;
        last_next    = last_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        base_next    = base_reg;
        rd_addr_next = rd_addr_reg;
        oor_next     = oor_reg;
        q_next       = q_reg;
        hold_next    = hold_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        yv_next      = yv_reg;
        sum_next     = sum_reg;
        for (int i = 0; i < 4; i++)
        begin
            xw_next[i] = xw_reg[i];
        end
        cmd       = '0;
        unit_a    = '0;
        unit_b    = '0;
        term_done = 1'b0;
        term_mag  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == cti_pkg::OP_QUERY))
                begin
                    q_next       = data_value;
                    oor_next     = 1'b0;
                    rd_addr_next = '0;
                    if (int'(table_length_reg) < cti_pkg::MIN_LENGTH)
                        last_next = IW'(cti_pkg::MIN_LENGTH - 1);
                    else if (int'(table_length_reg) > TABLE_DEPTH)
                        last_next = IW'(TABLE_DEPTH - 1);
                    else
                        last_next = IW'(int'(table_length_reg) - 1);
                    state_next = S_CHK0;
                end
            end
            S_CHK0:
            begin
                oor_next     = q_reg < x_rd;
                rd_addr_next = last_reg;
                state_next   = S_CHKN;
            end
            S_CHKN:
            begin
                oor_next = oor_reg || (q_reg > x_rd);
                if (q_reg == x_rd)
                begin
                    // point on the last x: last y directly
                    if (y_mode_reg)
                    begin
                        step_next  = STEP_LAST;
                        state_next = S_ISSUE;
                    end
                    else
                    begin
                        hold_next  = y_rd;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = last_reg;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (span > IW'(1))
                begin
                    rd_addr_next = lo_reg + (span >> 1);
                    state_next   = S_SCMP;
                end
                else
                begin
                    if (lo_reg == '0)
                        base_next = '0;
                    else if (lo_reg == last_reg - IW'(1))
                        base_next = last_reg - IW'(3);
                    else
                        base_next = lo_reg - IW'(1);
                    ld_cnt_next = '0;
                    state_next  = S_LDA;
                end
            end
            S_SCMP:
            begin
                if (x_rd <= q_reg)
                    lo_next = rd_addr_reg;
                else
                    hi_next = rd_addr_reg;
                state_next = S_SRCH;
            end
            S_LDA:
            begin
                rd_addr_next = base_reg + IW'(ld_cnt_reg);
                state_next   = S_LDB;
            end
            S_LDB:
            begin
                xw_next[3] = x_rd;
                for (int i = 0; i < 3; i++)
                begin
                    xw_next[i] = xw_reg[i + 1];
                end
                if (ld_cnt_reg == 2'd3)
                begin
                    k_next     = '0;
                    sum_next   = '0;
                    state_next = S_TERM;
                end
                else
                begin
                    ld_cnt_next = ld_cnt_reg + 2'd1;
                    state_next  = S_LDA;
                end
            end
            S_TERM:
            begin
                rd_addr_next = base_reg + IW'(k_reg);
                step_next    = STEP_N1;
                state_next   = S_ISSUE;
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
                cmd.start  = 1'b1;
                case (step_reg)
                    STEP_N1:
                    begin
                        unit_a = TW'(dq[1]);
                        unit_b = YW'(dq[2]);
                    end
                    STEP_N2:
                    begin
                        unit_a = TW'(num_reg);
                        unit_b = YW'(dq[3]);
                    end
                    STEP_D1:
                    begin
                        unit_a = TW'(dk[1]);
                        unit_b = YW'(dk[2]);
                    end
                    STEP_D2:
                    begin
                        unit_a = TW'(den_reg);
                        unit_b = YW'(dk[3]);
                    end
                    STEP_Y:
                    begin
                        unit_a = TW'(y_stride_reg);
                        unit_b = YW'(rd_addr_reg);
                    end
                    STEP_T:
                    begin
                        unit_a = TW'(num_reg);
                        unit_b = y_mode_reg ? yv_reg : YW'(y_rd);
                    end
                    STEP_DIV:
                    begin
                        if (den_reg == '0)
                        begin
                            // repeated x: the term is zero
                            cmd.start  = 1'b0;
                            term_done  = 1'b1;
                            state_next = S_TERM;
                        end
                        else
                        begin
                            cmd.divide = 1'b1;
                            unit_a     = unit_res;
                        end
                    end
                    STEP_LAST:
                    begin
                        unit_a = TW'(y_stride_reg);
                        unit_b = YW'(last_reg);
                    end
                    default:
                    begin
                        cmd.start = 1'b0;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (!unit_busy)
                begin
                    state_next = S_ISSUE;
                    case (step_reg)
                        STEP_N1:
                        begin
                            num_next  = unit_res[PW-1:0];
                            step_next = STEP_N2;
                        end
                        STEP_N2:
                        begin
                            num_next  = unit_res[PW-1:0];
                            step_next = STEP_D1;
                        end
                        STEP_D1:
                        begin
                            den_next  = unit_res[PW-1:0];
                            step_next = STEP_D2;
                        end
                        STEP_D2:
                        begin
                            den_next  = unit_res[PW-1:0];
                            step_next = y_mode_reg ? STEP_Y : STEP_T;
                        end
                        STEP_Y:
                        begin
                            yv_next   = unit_res[YW-1:0];
                            step_next = STEP_T;
                        end
                        STEP_T:
                        begin
                            step_next = STEP_DIV;
                        end
                        STEP_DIV:
                        begin
                            term_done  = 1'b1;
                            term_mag   = unit_res;
                            state_next = S_TERM;
                        end
                        STEP_LAST:
                        begin
                            hold_next  = (|unit_res[TW-1:VB]) ? '1 : unit_res[VB-1:0];
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                if (sum_reg[SW-1])
                    hold_next = '0;
                else if (|sum_reg[SW-2:VB])
                    hold_next = '1;
                else
                    hold_next = sum_reg[VB-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // close a term: accumulate, rotate the window to the next x_k
        if (term_done)
        begin
            sum_next   = term_neg ? (sum_reg - SW'(term_mag)) : (sum_reg + SW'(term_mag));
            xw_next[3] = xw_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                xw_next[i] = xw_reg[i + 1];
            end
            if (k_reg == 2'd3)
            begin
                state_next = S_FIN;
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= STEP_N1;
            k_reg            <= '0;
            ld_cnt_reg       <= '0;
            out_valid_reg    <= 1'b0;
            y_mode_reg       <= 1'b0;
            table_length_reg <= cti_pkg::LENGTH_RESET;
            y_stride_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            k_reg      <= k_next;
            ld_cnt_reg <= ld_cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    cti_pkg::CFG_Y_MODE:       y_mode_reg <= cfg_data[0];
                    cti_pkg::CFG_TABLE_LENGTH: table_length_reg <= cfg_data[cti_pkg::LENGTH_W-1:0];
                    cti_pkg::CFG_Y_STRIDE:     y_stride_reg <= cfg_data;
                    default:                   y_mode_reg <= y_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        base_reg    <= base_next;
        rd_addr_reg <= rd_addr_next;
        oor_reg     <= oor_next;
        q_reg       <= q_next;
        hold_reg    <= hold_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        yv_reg      <= yv_next;
        sum_reg     <= sum_next;
        for (int i = 0; i < 4; i++)
        begin
            xw_reg[i] <= xw_next[i];
        end
        if (out_load)
        begin
            result_reg  <= hold_reg;
            out_oor_reg <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign out_of_range = out_oor_reg;

    // unit is only started when free, and is idle whenever a transaction can enter
    `ASSERT_SAME(a_start_free, cmd.start, !unit_busy, "arith unit started while busy")
    `ASSERT_SAME(a_idle_free, in_ready, !unit_busy, "arith unit busy while idle")
    // a query holds off the next transaction
    `ASSERT_NEXT(a_query_blocks, accept && (opcode == cti_pkg::OP_QUERY), !in_ready,
        "ready right after a query")
    // search interval never collapses
    `ASSERT_SAME(a_search_order, state_reg == S_SRCH, lo_reg < hi_reg, "search bounds crossed")

endmodule

// ===== verif/cti_checker.sv =====
`timescale 1ns / 1ps

module cti_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cti_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [55:0]                       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [cti_pkg::OPCODE_W-1:0]      opcode,
    input  logic [cti_pkg::ENTRY_INDEX_W-1:0] entry_index,
    input  logic [55:0]                       data_value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [55:0]                       result_value,
    input  logic                              out_of_range,
    output int                                mismatches,
    output int                                pending
);
    localparam int DEPTH = 64;
    localparam logic [55:0] VMAX = {56{1'b1}};

    typedef logic signed [319:0] wide_t;
    typedef struct {
        logic [55:0] value;
        logic        oor;
    } interp_t;

    logic [55:0]                  xs [DEPTH];
    logic [55:0]                  ys [DEPTH];
    logic                         mode_q;
    logic [cti_pkg::LENGTH_W-1:0] len_q;
    logic [55:0]                  stride_q;
    interp_t                      interp_q [$];

    function automatic wide_t widen(logic [55:0] v);
        return signed'({264'b0, v});
    endfunction

    function automatic wide_t y_of(int i);
        if (mode_q)
            return widen(stride_q) * signed'(320'(i));
        return widen(ys[i]);
    endfunction

    function automatic logic [55:0] clip(wide_t s);
        if (s < 0)
            return '0;
        if (s > widen(VMAX))
            return VMAX;
        return s[55:0];
    endfunction

    function automatic interp_t interpolate(logic [55:0] q);
        interp_t r;
        int      n, lo, hi, mid, base;
        wide_t   sum, num, den, t;
        n = (len_q < cti_pkg::MIN_LENGTH) ? cti_pkg::MIN_LENGTH
          : (len_q > DEPTH) ? DEPTH : len_q;
        r.oor = (q < xs[0]) || (q > xs[n-1]);
        if (q == xs[n-1])
        begin
            r.value = clip(y_of(n-1));
            return r;
        end
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (xs[mid] <= q)
                lo = mid;
            else
                hi = mid;
        end
        base = (lo == 0) ? 0 : (lo == n - 2) ? n - 4 : lo - 1;
        sum = 0;
        for (int k = 0; k < 4; k++)
        begin
            num = 1;
            den = 1;
            for (int j = 0; j < 4; j++)
            begin
                if (j != k)
                begin
                    num = num * (widen(q) - widen(xs[base+j]));
                    den = den * (widen(xs[base+k]) - widen(xs[base+j]));
                end
            end
            t = y_of(base + k) * num;
            // coincident x points: the term drops out
            sum = sum + ((den == 0) ? wide_t'(0) : t / den);
        end
        r.value = clip(sum);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q     = 1'b0;
            len_q      = cti_pkg::LENGTH_RESET;
            stride_q   = '0;
            mismatches = 0;
            pending    = 0;
            interp_q.delete();
        end
        else
        begin
            interp_t got, want;
            if (cfg_we)
            begin
                case (cfg_index)
                    cti_pkg::CFG_Y_MODE:       mode_q = cfg_data[0];
                    cti_pkg::CFG_TABLE_LENGTH: len_q = cfg_data[cti_pkg::LENGTH_W-1:0];
                    cti_pkg::CFG_Y_STRIDE:     stride_q = cfg_data;
                    default: ;
                endcase
            end
            // result side first: a query accepted this edge cannot already be out
            if (out_valid && out_ready)
            begin
                got.value = result_value;
                got.oor   = out_of_range;
                if (interp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h oor %b", got.value, got.oor);
                end
                else
                begin
                    want = interp_q.pop_front();
                    if (got.value !== want.value || got.oor !== want.oor)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result exp %h/%b got %h/%b",
                                     want.value, want.oor, got.value, got.oor);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    cti_pkg::OP_WRITE_X: xs[entry_index] = data_value;
                    cti_pkg::OP_WRITE_Y: ys[entry_index] = data_value;
                    cti_pkg::OP_QUERY:   interp_q.push_back(interpolate(data_value));
                    default: ;
                endcase
            end
            pending = interp_q.size();
        end
    end
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic [55:0] VMAX = {56{1'b1}};
    localparam int DRAIN = 2300;   // extra wait after the results drain, to let the block settle

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [cti_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [55:0]                       cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [cti_pkg::OPCODE_W-1:0]      opcode;
    logic [cti_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic [55:0]                       data_value;
    logic                              out_valid;
    logic                              out_ready;
    logic [55:0]                       result_value;
    logic                              out_of_range;
    int                                mismatches;
    int                                pending;

    // idle percentages for the sender and the receiver
    int src_idle;
    int dst_stall;
    // stimulus-side copy of x, used only to aim queries at useful points
    logic [55:0] x_shadow [64];
    int          eff_len;

    cubic_table_interpolator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_index(entry_index), .data_value(data_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .out_of_range(out_of_range)
    );

    cti_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_index(entry_index), .data_value(data_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .out_of_range(out_of_range),
        .mismatches(mismatches), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= dst_stall);

    function automatic logic [55:0] rand56();
        return 56'({$urandom, $urandom});
    endfunction

    // one input transaction; returns right after the accepting edge
    task automatic send(logic [cti_pkg::OPCODE_W-1:0] op,
                        logic [cti_pkg::ENTRY_INDEX_W-1:0] idx,
                        logic [55:0] val);
        if ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        entry_index <= idx;
        data_value  <= val;
        if (op == cti_pkg::OP_WRITE_X)
            x_shadow[idx] = val;
        // in_ready is stable at the falling edge and decides the next rising one
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
    endtask

    // config only while idle: drain results, then let the block settle
    task automatic set_config(logic mode, logic [cti_pkg::LENGTH_W-1:0] len,
                              logic [55:0] stride);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= cti_pkg::CFG_Y_MODE;
        cfg_data  <= 56'(mode);
        @(posedge clk);
        cfg_index <= cti_pkg::CFG_TABLE_LENGTH;
        cfg_data  <= 56'(len);
        @(posedge clk);
        cfg_index <= cti_pkg::CFG_Y_STRIDE;
        cfg_data  <= stride;
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_len = (len < cti_pkg::MIN_LENGTH) ? cti_pkg::MIN_LENGTH : (len > 64) ? 64 : len;
    endtask

    // full reload of both tables; mostly ascending x, sometimes broken on purpose
    task automatic load_tables();
        int          shape;
        int          scale;
        logic [55:0] x;
        logic [55:0] y;
        shape = $urandom_range(9);
        scale = $urandom_range(49);
        x = (shape == 9) ? (VMAX - (56'd64 << scale)) : (rand56() >> (8 + $urandom_range(47)));
        if ($urandom_range(5) == 0)
            x = '0;
        for (int i = 0; i < 64; i++)
        begin
            case (shape)
                7:       x = rand56();                                   // no order at all
                8:       x = x + (($urandom_range(2) == 0) ? 56'd0 : 56'd1 << scale); // repeats
                default: x = x + 1 + (rand56() >> (55 - scale));
            endcase
            send(cti_pkg::OP_WRITE_X, 6'(i), x);
        end
        for (int i = 0; i < 64; i++)
        begin
            case ($urandom_range(5))
                0:       y = VMAX;
                1:       y = '0;
                2:       y = rand56() >> $urandom_range(55);
                default: y = rand56();
            endcase
            send(cti_pkg::OP_WRITE_Y, 6'(i), y);
        end
    endtask

    function automatic logic [55:0] pick_query();
        int          r;
        int          i;
        logic [55:0] lo;
        logic [55:0] hi;
        r  = $urandom_range(99);
        i  = $urandom_range(eff_len - 2);
        lo = x_shadow[0];
        hi = x_shadow[eff_len-1];
        if (r < 8)
            return (lo == 0) ? 56'd0 : rand56() % lo;                   // below the table
        if (r < 16)
            return (hi == VMAX) ? VMAX : hi + 1 + rand56() % (VMAX - hi); // above it
        if (r < 20)
            return hi;                                                    // last point
        if (r < 32)
            return x_shadow[i];                                           // on a knot
        if (r < 35)
            return rand56();
        if (x_shadow[i+1] > x_shadow[i])
            return x_shadow[i] + rand56() % (x_shadow[i+1] - x_shadow[i]);
        return x_shadow[i];
    endfunction

    // per phase: y mode, length (incl. out-of-range values), stride
    logic                         mode_set [8] = '{1'b0, 1'b1, 1'b0, 1'b1,
                                                   1'b0, 1'b1, 1'b0, 1'b1};
    logic [cti_pkg::LENGTH_W-1:0] len_set  [8] = '{7'd4, 7'd64, 7'd127, 7'd0,
                                                   7'd17, 7'd3, 7'd65, 7'd40};

    initial
    begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int r;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = cti_pkg::CFG_Y_MODE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = cti_pkg::OP_WRITE_X;
        entry_index = '0;
        data_value  = '0;
        src_idle    = 0;
        dst_stall   = 0;
        eff_len     = 40;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: uniform grid x = i, y = i^2, with the y extremes at the ends
        for (int i = 0; i < 64; i++)
            send(cti_pkg::OP_WRITE_X, 6'(i), 56'(i) << 24);
        for (int i = 0; i < 64; i++)
            send(cti_pkg::OP_WRITE_Y, 6'(i), (i == 63) ? VMAX : (56'(i * i) << 24));
        send(cti_pkg::OP_QUERY, '0, 56'd0);                       // first point
        send(cti_pkg::OP_QUERY, '0, 56'd39 << 24);                // last point at reset length
        send(cti_pkg::OP_QUERY, '0, (56'd11 << 24) + 56'h80_0000); // interior, half step
        send(cti_pkg::OP_QUERY, '0, 56'h00_0001);                  // first interval
        send(cti_pkg::OP_QUERY, '0, (56'd38 << 24) + 56'h1);       // last interval
        send(cti_pkg::OP_QUERY, '0, VMAX);                         // far above: extrapolate
        send(cti_pkg::OP_RESERVED, 6'd63, VMAX);                   // unused opcode
        set_config(1'b0, 7'd64, '0);
        send(cti_pkg::OP_QUERY, '0, (56'd62 << 24) + 56'h40_0000); // window holding y max
        send(cti_pkg::OP_QUERY, '0, 56'd63 << 24);
        set_config(1'b1, 7'd64, VMAX);                             // stride mode, saturating
        send(cti_pkg::OP_QUERY, '0, 56'd63 << 24);
        send(cti_pkg::OP_QUERY, '0, 56'd5 << 24);
        set_config(1'b1, 7'd4, 56'd1 << 24);
        send(cti_pkg::OP_QUERY, '0, 56'h00_1234);
        send(cti_pkg::OP_QUERY, '0, 56'd3 << 24);
        send(cti_pkg::OP_WRITE_X, 6'd0, 56'd1 << 24);              // x0 above 0: query below it
        send(cti_pkg::OP_QUERY, '0, 56'd0);

        // random phases: fresh table, then a mix aimed at queries
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:       begin src_idle = 0;  dst_stall = 0;  end
                1:       begin src_idle = 59; dst_stall = 0;  end
                2:       begin src_idle = 0;  dst_stall = 59; end
                default: begin src_idle = 8;  dst_stall = 8;  end
            endcase
            set_config(mode_set[p], len_set[p],
                       (p == 1) ? VMAX : (p == 3) ? '0 : rand56() >> $urandom_range(55));
            load_tables();
            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    send(cti_pkg::OP_QUERY, 6'($urandom), pick_query());
                else if (r < 85)
                    send(cti_pkg::OP_WRITE_Y, 6'($urandom), rand56());
                else if (r < 93)
                    send(cti_pkg::OP_WRITE_X, 6'($urandom), rand56());
                else
                    send(cti_pkg::OP_RESERVED, 6'($urandom), rand56());
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
